/* rtl/dgsf_pkg.sv */
package dgsf_pkg;

  localparam int Width = 32;
  localparam int FracBits = 16;
  localparam int ProdWidth = 2 * Width;
  localparam int NumStages = 7;
  localparam int LiftWidth = 7;
  localparam int OrderWidth = 4;
  localparam int CfgIndexWidth = 4;

  localparam logic [CfgIndexWidth-1:0] CfgPolyOrder = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] CfgUpwind = CfgIndexWidth'(1);

  localparam logic [LiftWidth-1:0] LiftReset = LiftWidth'(1);
  localparam logic signed [Width-1:0] UpwindReset = Width'(32768);

  localparam logic signed [ProdWidth-1:0] RoundConst = ProdWidth'(1) <<< (FracBits - 1);
  localparam logic signed [Width-1:0] QMax = {1'b0, {(Width - 1) {1'b1}}};
  localparam logic signed [Width-1:0] QMin = {1'b1, {(Width - 1) {1'b0}}};

  typedef logic signed [Width-1:0] q_t;

  typedef struct packed {
    q_t normal_x;
    q_t normal_y;
    q_t surface_jacobian;
    q_t inverse_jacobian;
    q_t inner_u;
    q_t inner_v;
    q_t inner_p;
    q_t outer_u;
    q_t outer_v;
    q_t outer_p;
    logic at_boundary;
  } node_t;

  typedef struct packed {
    q_t du_increment;
    q_t dv_increment;
    q_t dp_increment;
  } flux_t;

  typedef struct packed {
    logic [LiftWidth-1:0] lift;
    q_t upwind;
  } cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } ctl_t;

  function automatic q_t sat_wide(input logic signed [ProdWidth-1:0] x);
    if (x > ProdWidth'(QMax)) begin
      return QMax;
    end else if (x < ProdWidth'(QMin)) begin
      return QMin;
    end
    return x[Width-1:0];
  endfunction

  function automatic q_t neg_sat(input q_t x);
    if (x == QMin) begin
      return QMax;
    end
    return -x;
  endfunction

  function automatic q_t add_sat(input q_t a, input q_t b);
    return sat_wide(ProdWidth'(a) + ProdWidth'(b));
  endfunction

  function automatic q_t sub_sat(input q_t a, input q_t b);
    return sat_wide(ProdWidth'(a) - ProdWidth'(b));
  endfunction

  function automatic q_t half_q(input q_t x);
    logic signed [Width:0] h;
    h = ((Width + 1)'(x) + (Width + 1)'(1)) >>> 1;
    return h[Width-1:0];
  endfunction

  // Fixed-point product, rounded half up and saturated.
  function automatic q_t mul_q(input q_t a, input q_t b);
    logic signed [ProdWidth-1:0] p;
    logic signed [ProdWidth-1:0] r;
    p = ProdWidth'(a) * ProdWidth'(b);
    r = (p + RoundConst) >>> FracBits;
    return sat_wide(r);
  endfunction

endpackage

/* rtl/node_if.sv */
interface node_if;
  logic valid;
  logic ready;
  dgsf_pkg::q_t normal_x;
  dgsf_pkg::q_t normal_y;
  dgsf_pkg::q_t surface_jacobian;
  dgsf_pkg::q_t inverse_jacobian;
  dgsf_pkg::q_t inner_u;
  dgsf_pkg::q_t inner_v;
  dgsf_pkg::q_t inner_p;
  dgsf_pkg::q_t outer_u;
  dgsf_pkg::q_t outer_v;
  dgsf_pkg::q_t outer_p;
  logic at_boundary;

  modport source (
    output valid, normal_x, normal_y, surface_jacobian, inverse_jacobian,
    output inner_u, inner_v, inner_p, outer_u, outer_v, outer_p, at_boundary,
    input ready
  );
  modport sink (
    input valid, normal_x, normal_y, surface_jacobian, inverse_jacobian,
    input inner_u, inner_v, inner_p, outer_u, outer_v, outer_p, at_boundary,
    output ready
  );
endinterface

/* rtl/flux_if.sv */
interface flux_if;
  logic valid;
  logic ready;
  dgsf_pkg::q_t du_increment;
  dgsf_pkg::q_t dv_increment;
  dgsf_pkg::q_t dp_increment;

  modport source (
    output valid, du_increment, dv_increment, dp_increment,
    input ready
  );
  modport sink (
    input valid, du_increment, dv_increment, dp_increment,
    output ready
  );
endinterface

/* rtl/cfg_if.sv */
interface cfg_if;
  logic valid;
  logic ready;
  logic [dgsf_pkg::CfgIndexWidth-1:0] index;
  logic [dgsf_pkg::Width-1:0] data;

  modport source (
    output valid, index, data,
    input ready
  );
  modport sink (
    input valid, index, data,
    output ready
  );
endinterface

/* rtl/dgsf_cfg.sv */
module dgsf_cfg (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [dgsf_pkg::CfgIndexWidth-1:0] wr_index,
  input  logic [dgsf_pkg::Width-1:0] wr_data,
  output dgsf_pkg::cfg_t cfg
);

  logic [dgsf_pkg::OrderWidth-1:0] order;
  logic [2*dgsf_pkg::OrderWidth:0] order_prod;
  logic [dgsf_pkg::LiftWidth-1:0] lift_next;

  // The lift factor N(N+1)/2 is formed from the write data and stored on a polynomial-order write.
  assign order = wr_data[dgsf_pkg::OrderWidth-1:0];
  assign order_prod = (2 * dgsf_pkg::OrderWidth + 1)'(order)
                    * (2 * dgsf_pkg::OrderWidth + 1)'({1'b0, order} + 1'b1);
  assign lift_next = order_prod[dgsf_pkg::LiftWidth:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lift <= dgsf_pkg::LiftReset;
      cfg.upwind <= dgsf_pkg::UpwindReset;
    end else if (wr_en) begin
      case (wr_index)
        dgsf_pkg::CfgPolyOrder: cfg.lift <= lift_next;
        dgsf_pkg::CfgUpwind: cfg.upwind <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/dgsf_ctl.sv */
module dgsf_ctl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output dgsf_pkg::ctl_t ctl
);

  logic [dgsf_pkg::NumStages-1:0] valid;
  logic [dgsf_pkg::NumStages-1:0] valid_next;
  logic [dgsf_pkg::NumStages-1:0] load;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    load[dgsf_pkg::NumStages-1] = !valid[dgsf_pkg::NumStages-1] || out_ready;
    for (int k = dgsf_pkg::NumStages - 2; k >= 0; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  assign valid_next = {valid[dgsf_pkg::NumStages-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (load & valid_next) | (~load & valid);
    end
  end

  assign in_ready = load[0];
  assign out_valid = valid[dgsf_pkg::NumStages-1];
  assign ctl.load = load;

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> valid[dgsf_pkg::NumStages-1] && !out_ready)
    else $error("input stalled without a held output beat");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid[0])
    else $error("accepted beat missing from first stage");

  a_first_stage_holds: assert property (@(posedge clk) disable iff (rst)
    valid[0] && !load[0] |=> valid[0])
    else $error("stalled first stage lost its beat");

endmodule

/* rtl/dgsf_datapath.sv */
module dgsf_datapath (
  input  logic clk,
  input  dgsf_pkg::ctl_t ctl,
  input  dgsf_pkg::cfg_t cfg,
  input  dgsf_pkg::node_t node,
  output dgsf_pkg::flux_t flux
);

  // Stage 1: exterior state and jumps.
  dgsf_pkg::q_t s1_du, s1_dv, s1_dp, s1_nx, s1_ny, s1_ij, s1_sj;
  // Stage 2: first products.
  dgsf_pkg::q_t s2_t, s2_a, s2_b, s2_g0, s2_hdu, s2_hdv, s2_hdp, s2_nx, s2_ny;
  // Stage 3: normal times penalty, velocity sum, geometric factor.
  dgsf_pkg::q_t s3_m1, s3_m2, s3_s, s3_g, s3_hdu, s3_hdv, s3_hdp, s3_nx, s3_ny;
  // Stage 4: velocity flux jumps and pressure penalty.
  dgsf_pkg::q_t s4_dus, s4_dvs, s4_c, s4_hdp, s4_g, s4_nx, s4_ny;
  // Stage 5: pressure flux jump and projections.
  dgsf_pkg::q_t s5_dps, s5_e, s5_f, s5_g, s5_nx, s5_ny;
  // Stage 6: normal components.
  dgsf_pkg::q_t s6_x0, s6_x1, s6_y, s6_g;

  dgsf_pkg::q_t up_sel, vp_sel, pp_sel;
  logic signed [dgsf_pkg::Width+dgsf_pkg::LiftWidth:0] lift_prod;

  assign up_sel = node.at_boundary ? dgsf_pkg::neg_sat(node.inner_u) : node.outer_u;
  assign vp_sel = node.at_boundary ? dgsf_pkg::neg_sat(node.inner_v) : node.outer_v;
  assign pp_sel = node.at_boundary ? node.inner_p : node.outer_p;

  assign lift_prod = $signed({1'b0, cfg.lift}) * s2_g0;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_du <= dgsf_pkg::sub_sat(up_sel, node.inner_u);
      s1_dv <= dgsf_pkg::sub_sat(vp_sel, node.inner_v);
      s1_dp <= dgsf_pkg::sub_sat(pp_sel, node.inner_p);
      s1_nx <= node.normal_x;
      s1_ny <= node.normal_y;
      s1_ij <= node.inverse_jacobian;
      s1_sj <= node.surface_jacobian;
    end
    if (ctl.load[1]) begin
      s2_t <= dgsf_pkg::mul_q(cfg.upwind, s1_dp);
      s2_a <= dgsf_pkg::mul_q(s1_nx, s1_du);
      s2_b <= dgsf_pkg::mul_q(s1_ny, s1_dv);
      s2_g0 <= dgsf_pkg::mul_q(s1_ij, s1_sj);
      s2_hdu <= dgsf_pkg::half_q(s1_du);
      s2_hdv <= dgsf_pkg::half_q(s1_dv);
      s2_hdp <= dgsf_pkg::half_q(s1_dp);
      s2_nx <= s1_nx;
      s2_ny <= s1_ny;
    end
    if (ctl.load[2]) begin
      s3_m1 <= dgsf_pkg::mul_q(s2_nx, s2_t);
      s3_m2 <= dgsf_pkg::mul_q(s2_ny, s2_t);
      s3_s <= dgsf_pkg::add_sat(s2_a, s2_b);
      s3_g <= dgsf_pkg::sat_wide(dgsf_pkg::ProdWidth'(lift_prod));
      s3_hdu <= s2_hdu;
      s3_hdv <= s2_hdv;
      s3_hdp <= s2_hdp;
      s3_nx <= s2_nx;
      s3_ny <= s2_ny;
    end
    if (ctl.load[3]) begin
      s4_dus <= dgsf_pkg::sub_sat(s3_hdu, s3_m1);
      s4_dvs <= dgsf_pkg::sub_sat(s3_hdv, s3_m2);
      s4_c <= dgsf_pkg::mul_q(cfg.upwind, s3_s);
      s4_hdp <= s3_hdp;
      s4_g <= s3_g;
      s4_nx <= s3_nx;
      s4_ny <= s3_ny;
    end
    if (ctl.load[4]) begin
      s5_dps <= dgsf_pkg::sub_sat(s4_hdp, s4_c);
      s5_e <= dgsf_pkg::mul_q(s4_nx, s4_dus);
      s5_f <= dgsf_pkg::mul_q(s4_ny, s4_dvs);
      s5_g <= s4_g;
      s5_nx <= s4_nx;
      s5_ny <= s4_ny;
    end
    if (ctl.load[5]) begin
      s6_x0 <= dgsf_pkg::mul_q(s5_nx, s5_dps);
      s6_x1 <= dgsf_pkg::mul_q(s5_ny, s5_dps);
      s6_y <= dgsf_pkg::add_sat(s5_e, s5_f);
      s6_g <= s5_g;
    end
    if (ctl.load[6]) begin
      flux.du_increment <= dgsf_pkg::neg_sat(dgsf_pkg::mul_q(s6_g, s6_x0));
      flux.dv_increment <= dgsf_pkg::neg_sat(dgsf_pkg::mul_q(s6_g, s6_x1));
      flux.dp_increment <= dgsf_pkg::neg_sat(dgsf_pkg::mul_q(s6_g, s6_y));
    end
  end

endmodule

/* rtl/dg_acoustic_surface_flux.sv */
// Each accepted node beat yields one flux beat, in order.
// Throughput: one node per cycle; the seven-stage pipeline takes a beat every cycle
// and a stage holds only while the stages after it are full and the output is stalled.
// Reset clears every stage's valid bit and sets the polynomial order to 1 and the
// upwind coefficient to 0.5; data registers keep whatever they held.
module dg_acoustic_surface_flux (
  input logic clk,
  input logic rst,
  cfg_if.sink cfg,
  node_if.sink node,
  flux_if.source flux
);

  dgsf_pkg::cfg_t cfg_regs;
  dgsf_pkg::ctl_t ctl;
  dgsf_pkg::node_t node_beat;
  dgsf_pkg::flux_t flux_beat;

  assign cfg.ready = 1'b1;

  assign node_beat.normal_x = node.normal_x;
  assign node_beat.normal_y = node.normal_y;
  assign node_beat.surface_jacobian = node.surface_jacobian;
  assign node_beat.inverse_jacobian = node.inverse_jacobian;
  assign node_beat.inner_u = node.inner_u;
  assign node_beat.inner_v = node.inner_v;
  assign node_beat.inner_p = node.inner_p;
  assign node_beat.outer_u = node.outer_u;
  assign node_beat.outer_v = node.outer_v;
  assign node_beat.outer_p = node.outer_p;
  assign node_beat.at_boundary = node.at_boundary;

  dgsf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  dgsf_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (node.valid),
    .in_ready  (node.ready),
    .out_valid (flux.valid),
    .out_ready (flux.ready),
    .ctl       (ctl)
  );

  dgsf_datapath u_datapath (
    .clk  (clk),
    .ctl  (ctl),
    .cfg  (cfg_regs),
    .node (node_beat),
    .flux (flux_beat)
  );

  assign flux.du_increment = flux_beat.du_increment;
  assign flux.dv_increment = flux_beat.dv_increment;
  assign flux.dp_increment = flux_beat.dp_increment;

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dgsf_pkg::*;

  typedef logic signed [ProdWidth-1:0] wide_t;

  typedef struct {
    logic [OrderWidth-1:0] order;
    q_t coeff;
    node_t beat;
    bit typed;
    flux_t want;
  } drow_t;

  localparam q_t One = q_t'(1) <<< FracBits;
  localparam q_t NegOne = -One;
  localparam q_t Half = One >>> 1;
  localparam logic [OrderWidth-1:0] OrderReset = OrderWidth'(1);
  localparam int FirstUnusedIndex = int'(CfgUpwind) + 1;
  localparam int LastIndex = (1 << CfgIndexWidth) - 1;
  localparam int IdlePct = 19;
  localparam int RandomItems = 1935;
  localparam int Phases = 9;
  localparam int HoldCycles = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  node_if node_ch ();
  flux_if flux_ch ();
  cfg_if cfg_ch ();

  dg_acoustic_surface_flux u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .node(node_ch),
    .flux(flux_ch)
  );

  flux_t expected_flux[$];
  drow_t directed_rows[$];
  logic [OrderWidth-1:0] model_order = OrderReset;
  q_t model_upwind = UpwindReset;
  int mismatches = 0;
  int hold_cycles = 0;
  bit steady = 1'b0;
  flux_t oldest;

  always #2 clk = ~clk;

  function automatic q_t clamp_q(wide_t x);
    if (x > wide_t'(QMax)) begin
      return QMax;
    end
    if (x < wide_t'(QMin)) begin
      return QMin;
    end
    return x[Width-1:0];
  endfunction

  function automatic wide_t scale_down(wide_t x, int s);
    return (x + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic q_t qmul(q_t a, q_t b);
    return clamp_q(scale_down(wide_t'(a) * wide_t'(b), FracBits));
  endfunction

  function automatic flux_t upwind_flux(node_t n, logic [OrderWidth-1:0] order, q_t lam);
    q_t up, vp, pp, du, dv, dp, t, dus, dvs, dps, g;
    int lift;
    flux_t f;
    up = n.outer_u;
    vp = n.outer_v;
    pp = n.outer_p;
    if (n.at_boundary) begin
      up = clamp_q(-wide_t'(n.inner_u));
      vp = clamp_q(-wide_t'(n.inner_v));
      pp = n.inner_p;
    end
    du = clamp_q(wide_t'(up) - wide_t'(n.inner_u));
    dv = clamp_q(wide_t'(vp) - wide_t'(n.inner_v));
    dp = clamp_q(wide_t'(pp) - wide_t'(n.inner_p));
    t = qmul(lam, dp);
    dus = clamp_q(scale_down(wide_t'(du), 1) - wide_t'(qmul(n.normal_x, t)));
    dvs = clamp_q(scale_down(wide_t'(dv), 1) - wide_t'(qmul(n.normal_y, t)));
    dps = clamp_q(scale_down(wide_t'(dp), 1) - wide_t'(qmul(lam,
        clamp_q(wide_t'(qmul(n.normal_x, du)) + wide_t'(qmul(n.normal_y, dv))))));
    lift = int'(order) * (int'(order) + 1) / 2;
    g = clamp_q(wide_t'(lift) * wide_t'(qmul(n.inverse_jacobian, n.surface_jacobian)));
    f.du_increment = clamp_q(-wide_t'(qmul(g, qmul(n.normal_x, dps))));
    f.dv_increment = clamp_q(-wide_t'(qmul(g, qmul(n.normal_y, dps))));
    f.dp_increment = clamp_q(-wide_t'(qmul(g,
        clamp_q(wide_t'(qmul(n.normal_x, dus)) + wide_t'(qmul(n.normal_y, dvs))))));
    return f;
  endfunction

  function automatic q_t any_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return q_t'($urandom);
    end
    if (pick < 70) begin
      return q_t'(int'($urandom_range(32'h7FFFF)) - 32'sh40000);
    end
    if (pick < 85) begin
      return q_t'(int'($urandom_range(15)) - 8);
    end
    case ($urandom_range(4))
      0: return QMax;
      1: return QMin;
      2: return One;
      3: return NegOne;
      default: return '0;
    endcase
  endfunction

  function automatic q_t near_unit();
    if ($urandom_range(9) < 7) begin
      return q_t'(int'($urandom_range(32'h3FFFF)) - 32'sh20000);
    end
    return any_value();
  endfunction

  function automatic node_t random_node();
    node_t n;
    n.normal_x = near_unit();
    n.normal_y = near_unit();
    n.surface_jacobian = near_unit();
    n.inverse_jacobian = near_unit();
    n.inner_u = any_value();
    n.inner_v = any_value();
    n.inner_p = any_value();
    n.outer_u = any_value();
    n.outer_v = any_value();
    n.outer_p = any_value();
    n.at_boundary = ($urandom_range(3) == 0);
    return n;
  endfunction

  function automatic node_t make_node(q_t nx, q_t ny, q_t sj, q_t ij, q_t um, q_t vm,
                                      q_t pm, q_t up, q_t vp, q_t pp, logic bnd);
    node_t n;
    n.normal_x = nx;
    n.normal_y = ny;
    n.surface_jacobian = sj;
    n.inverse_jacobian = ij;
    n.inner_u = um;
    n.inner_v = vm;
    n.inner_p = pm;
    n.outer_u = up;
    n.outer_v = vp;
    n.outer_p = pp;
    n.at_boundary = bnd;
    return n;
  endfunction

  function automatic drow_t make_row(logic [OrderWidth-1:0] order, q_t coeff, node_t beat,
                                     bit typed, flux_t want);
    drow_t r;
    r.order = order;
    r.coeff = coeff;
    r.beat = beat;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  task automatic report(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, q_t got, q_t want);
    if (got !== want) begin
      report($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic send_node(node_t n, bit typed, flux_t want);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IdlePct) begin
      node_ch.valid = 1'b0;
      @(negedge clk);
    end
    node_ch.normal_x = n.normal_x;
    node_ch.normal_y = n.normal_y;
    node_ch.surface_jacobian = n.surface_jacobian;
    node_ch.inverse_jacobian = n.inverse_jacobian;
    node_ch.inner_u = n.inner_u;
    node_ch.inner_v = n.inner_v;
    node_ch.inner_p = n.inner_p;
    node_ch.outer_u = n.outer_u;
    node_ch.outer_v = n.outer_v;
    node_ch.outer_p = n.outer_p;
    node_ch.at_boundary = n.at_boundary;
    node_ch.valid = 1'b1;
    @(posedge clk);
    while (!node_ch.ready) begin
      @(posedge clk);
    end
    expected_flux.push_back(typed ? want : upwind_flux(n, model_order, model_upwind));
  endtask

  task automatic await_results();
    @(negedge clk);
    node_ch.valid = 1'b0;
    while (expected_flux.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [Width-1:0] value);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    if (idx == CfgPolyOrder) begin
      model_order = value[OrderWidth-1:0];
    end else if (idx == CfgUpwind) begin
      model_upwind = q_t'(value);
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_setting(logic [OrderWidth-1:0] order, q_t coeff);
    logic [Width-1:0] raw;
    raw = $urandom;
    raw[OrderWidth-1:0] = order;
    write_reg(CfgPolyOrder, raw);
    write_reg(CfgIndexWidth'($urandom_range(LastIndex, FirstUnusedIndex)), $urandom);
    write_reg(CfgUpwind, coeff);
  endtask

  always @(posedge clk) begin
    if (!rst && flux_ch.valid && flux_ch.ready) begin
      if (expected_flux.size() == 0) begin
        report("flux beat arrived with no node outstanding");
      end else begin
        oldest = expected_flux.pop_front();
        check_field("du_increment", flux_ch.du_increment, oldest.du_increment);
        check_field("dv_increment", flux_ch.dv_increment, oldest.dv_increment);
        check_field("dp_increment", flux_ch.dp_increment, oldest.dp_increment);
      end
    end
  end

  initial begin
    flux_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        flux_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        flux_ch.ready = steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int ph;
    int i;
    logic [OrderWidth-1:0] order;
    q_t coeff;

    node_ch.valid = 1'b0;
    node_ch.normal_x = '0;
    node_ch.normal_y = '0;
    node_ch.surface_jacobian = '0;
    node_ch.inverse_jacobian = '0;
    node_ch.inner_u = '0;
    node_ch.inner_v = '0;
    node_ch.inner_p = '0;
    node_ch.outer_u = '0;
    node_ch.outer_v = '0;
    node_ch.outer_p = '0;
    node_ch.at_boundary = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    // The first rows run on the reset settings, so their typed results also check them.
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b1, '0));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node(One, '0, One, One, '0, '0, '0, '0, '0, One, 1'b0), 1'b1,
        flux_t'{-Half, q_t'(0), Half}));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node(One, One, One, One, '0, '0, QMax, QMin, QMin, QMin, 1'b1), 1'b1, '0));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node(QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, 1'b0),
        1'b0, '0));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, 1'b0),
        1'b0, '0));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node(One, NegOne, One, One, QMin, QMin, QMax, '0, '0, '0, 1'b1), 1'b0, '0));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node(q_t'(-1), q_t'(1), One, One, '0, '0, '0, q_t'(1), q_t'(-1), q_t'(1), 1'b0),
        1'b0, '0));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1), 1'b0, '0));
    directed_rows.push_back(make_row(OrderReset, UpwindReset,
        make_node(q_t'(32'h5555_5555), q_t'(32'hAAAA_AAAA), q_t'(32'h5555_5555),
                  q_t'(32'hAAAA_AAAA), q_t'(32'h5555_5555), q_t'(32'hAAAA_AAAA),
                  q_t'(32'h5555_5555), q_t'(32'hAAAA_AAAA), q_t'(32'h5555_5555),
                  q_t'(32'hAAAA_AAAA), 1'b0), 1'b0, '0));
    directed_rows.push_back(make_row('0, UpwindReset,
        make_node(QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, 1'b0),
        1'b1, '0));
    directed_rows.push_back(make_row('0, QMin,
        make_node(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, 1'b1),
        1'b1, '0));
    directed_rows.push_back(make_row('1, QMax,
        make_node(QMax, QMin, QMax, QMax, QMin, QMax, QMin, QMax, QMin, QMax, 1'b0),
        1'b0, '0));
    directed_rows.push_back(make_row('1, QMax,
        make_node(One, One, One, One, Half, -Half, One, '0, '0, '0, 1'b1), 1'b0, '0));
    directed_rows.push_back(make_row('1, QMin,
        make_node(QMin, QMax, QMin, QMin, QMax, QMin, QMax, QMin, QMax, QMin, 1'b1),
        1'b0, '0));
    directed_rows.push_back(make_row('1, '0,
        make_node(One, NegOne, Half, One <<< 2, One, '0, NegOne, '0, One, One, 1'b0),
        1'b0, '0));
    directed_rows.push_back(make_row(OrderWidth'(7), NegOne,
        make_node(Half, -Half, One <<< 1, One, One, NegOne, Half, '0, One, -Half, 1'b0),
        1'b0, '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].order != model_order || directed_rows[k].coeff != model_upwind) begin
        await_results();
        apply_setting(directed_rows[k].order, directed_rows[k].coeff);
      end
      send_node(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);
    end

    for (ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin
          order = '1;
          coeff = QMax;
        end
        1: begin
          order = OrderReset;
          coeff = QMin;
        end
        2: begin
          order = '0;
          coeff = any_value();
        end
        3: begin
          order = '1;
          coeff = '0;
        end
        default: begin
          order = OrderWidth'($urandom_range(15, 1));
          coeff = any_value();
        end
      endcase
      await_results();
      apply_setting(order, coeff);
      steady = (ph == 3);
      for (i = 0; i < RandomItems / Phases; i++) begin
        if (ph == 1 && i == 40) begin
          hold_cycles = HoldCycles;
        end
        if (ph == 5 && i == RandomItems / Phases / 2) begin
          await_results();
        end
        send_node(random_node(), 1'b0, '0);
      end
    end

    await_results();
    repeat (4 * NumStages) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
